// File: hw/rtl/sliding_window_average_assert.svh
// assertion macros shared by the sliding window average modules
`ifndef SLIDING_WINDOW_AVERAGE_ASSERT_SVH
`define SLIDING_WINDOW_AVERAGE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while arst_n is low
`define SWA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swa assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SWA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swa assertion failed");

`else

`define SWA_ASSERT_NOW(label, ante, cons)
`define SWA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/swa_pkg.sv
// shared types and constants of the sliding window average
package swa_pkg;

	// width of the window size register
	localparam int CFG_W = 11;
	// window size after reset
	localparam int WIN_RESET = 16;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic add;
		logic update;
		logic div_start;
		logic div_step;
		logic out_load;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_last;
		logic out_busy;
	} ctl_sts_t;

endpackage

// File: hw/rtl/swa_ctrl.sv
// controller state machine of the sliding window average
`include "sliding_window_average_assert.svh"

module swa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  swa_pkg::ctl_sts_t sts,
	output swa_pkg::ctl_cmd_t cmd
);
	import swa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_PREP,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   accept;

	assign accept   = in_valid && !in_stall_q;
	assign in_stall = in_stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_READ;
						in_stall_q <= 1'b1;
					end
				end
				ST_READ:   state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= ST_PREP;
				ST_PREP:   state_q <= ST_DIVIDE;
				ST_DIVIDE: begin
					if (sts.div_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!sts.out_busy) begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.load      = accept;
			ST_READ:   cmd.add       = 1'b1;
			ST_UPDATE: cmd.update    = 1'b1;
			ST_PREP:   cmd.div_start = 1'b1;
			ST_DIVIDE: cmd.div_step  = 1'b1;
			ST_FINISH: cmd.out_load  = !sts.out_busy;
			default:   cmd           = '0;
		endcase
	end

	`SWA_ASSERT_NEXT(a_accept_starts, accept, (state_q == ST_READ) && in_stall_q)
	`SWA_ASSERT_NEXT(a_div_ends, (state_q == ST_DIVIDE) && sts.div_last, state_q == ST_FINISH)
	`SWA_ASSERT_NOW(a_stall_outside_idle, state_q != ST_IDLE, in_stall_q)

endmodule

// File: hw/rtl/swa_datapath.sv
// ring memory, running sum, serial divider and output register
`include "sliding_window_average_assert.svh"

module swa_datapath #(
	parameter int WINDOW_MAX   = 1024,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swa_pkg::ctl_cmd_t              cmd,
	output swa_pkg::ctl_sts_t              sts,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           win_len_we,
	input  logic [swa_pkg::CFG_W-1:0]      win_len,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] average,
	output logic                           window_full
);
	import swa_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W  = SAMPLE_WIDTH + SLOT_W;
	localparam int STEP_W = $clog2(SUM_W);
	localparam int CMP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;

	// window length in use: zero means one, large values saturate
	function automatic logic [CNT_W-1:0] clamp_win(input logic [CFG_W-1:0] w);
		logic [CMP_W-1:0] wx;
		wx = CMP_W'(w);
		if (wx == '0) begin
			wx = CMP_W'(1);
		end else if (wx > CMP_W'(WINDOW_MAX)) begin
			wx = CMP_W'(WINDOW_MAX);
		end
		return wx[CNT_W-1:0];
	endfunction

	localparam logic [CNT_W-1:0] WIN_RST = clamp_win(CFG_W'(WIN_RESET));

	logic [SAMPLE_WIDTH-1:0]        ring_mem [WINDOW_MAX];
	logic [SAMPLE_WIDTH-1:0]        ring_rd_q;
	logic [CNT_W-1:0]               win_q;
	logic [CNT_W-1:0]               held_q;
	logic [SLOT_W-1:0]              slot_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic                           neg_q;
	logic [SUM_W-1:0]               dq_q;
	logic [CNT_W-1:0]               rem_q;
	logic [STEP_W-1:0]              step_q;
	logic                           full_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] average_q;
	logic                           window_full_q;

	logic                           full_now;
	logic [CNT_W-1:0]               held_next;
	logic [CNT_W-1:0]               slot_inc;
	logic signed [SUM_W-1:0]        sample_ext;
	logic signed [SUM_W-1:0]        old_ext;
	logic [SUM_W-1:0]               sum_mag;
	logic [CNT_W:0]                 trial;
	logic [CNT_W:0]                 diff;
	logic                           ge;
	logic [SAMPLE_WIDTH-1:0]        quot;

	assign full_now   = (held_q == win_q);
	assign held_next  = full_now ? win_q : held_q + 1'b1;
	assign slot_inc   = CNT_W'(slot_q) + 1'b1;
	assign sample_ext = {{(SUM_W - SAMPLE_WIDTH){sample_s1[SAMPLE_WIDTH-1]}}, sample_s1};
	assign old_ext    = {{(SUM_W - SAMPLE_WIDTH){ring_rd_q[SAMPLE_WIDTH-1]}}, ring_rd_q};
	assign sum_mag    = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

	// one restoring divide step per cycle
	assign trial = {rem_q, dq_q[SUM_W-1]};
	assign ge    = (trial >= {1'b0, held_q});
	assign diff  = trial - {1'b0, held_q};
	assign quot  = dq_q[SAMPLE_WIDTH-1:0];

	// ring memory, read of the oldest entry at accept, write at update
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			ring_mem[slot_q] <= sample_s1;
		end
		if (cmd.load) begin
			ring_rd_q <= ring_mem[slot_q];
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= WIN_RST;
			held_q      <= '0;
			slot_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (win_len_we) begin
				win_q  <= clamp_win(win_len);
				held_q <= '0;
				slot_q <= '0;
				sum_q  <= '0;
			end else if (cmd.add) begin
				sum_q <= sum_q + sample_ext;
			end else if (cmd.update) begin
				sum_q  <= full_now ? (sum_q - old_ext) : sum_q;
				held_q <= held_next;
				slot_q <= (slot_inc == win_q) ? '0 : slot_inc[SLOT_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and divider registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_s1 <= sample;
		end
		if (cmd.update) begin
			full_q <= (held_next == win_q);
		end
		if (cmd.div_start) begin
			neg_q  <= sum_q[SUM_W-1];
			dq_q   <= sum_mag;
			rem_q  <= '0;
			step_q <= STEP_W'(SUM_W - 1);
		end else if (cmd.div_step) begin
			dq_q   <= {dq_q[SUM_W-2:0], ge};
			rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			step_q <= step_q - 1'b1;
		end
		if (cmd.out_load) begin
			average_q     <= neg_q ? (~quot + 1'b1) : quot;
			window_full_q <= full_q;
		end
	end

	assign sts.div_last = (step_q == '0);
	assign sts.out_busy = out_valid_q && out_stall;

	assign out_valid   = out_valid_q;
	assign average     = average_q;
	assign window_full = window_full_q;

	`SWA_ASSERT_NOW(a_held_in_window, 1'b1, held_q <= win_q)
	`SWA_ASSERT_NOW(a_slot_in_window, 1'b1, CNT_W'(slot_q) < win_q)
	`SWA_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid_q)

endmodule

// File: hw/rtl/sliding_window_average.sv
// sliding window average: boxcar mean over the most recent samples
// one sample at a time: in_stall stays high from input transfer until the result
//   is loaded into the output register, the divide done by the one-bit-per-cycle
//   restoring divider on SUM_W-bit sums; SUM_W = SAMPLE_WIDTH + log2(WINDOW_MAX)
// reset (arst_n low, asynchronous): window size 16, count, sum and slot cleared;
//   the ring memory is not cleared, an entry is only used after it was written
module sliding_window_average #(
	parameter int WINDOW_MAX   = 1024,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] average,
	output logic                           window_full,
	// window size register, write restarts the filter
	input  logic                           win_len_we,
	input  logic [swa_pkg::CFG_W-1:0]      win_len
);
	import swa_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// controller: one item at a time through read, sum update, divide and finish;
	// the next sample transfer is taken while the last result still waits
	// in the output register
	swa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: ring memory of the last samples, running sum with removal of
	// the oldest sample once the window is full, and serial divide of the sum
	// magnitude by the sample count, sign applied after (truncation to zero)
	swa_datapath #(
		.WINDOW_MAX   (WINDOW_MAX),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (sample),
		.win_len_we  (win_len_we),
		.win_len     (win_len),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.average     (average),
		.window_full (window_full)
	);

endmodule

// File: tb/sv/tb_sliding_window_average.sv
// testbench for the sliding window average: table-driven and random samples vs a predictor
module tb_sliding_window_average;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_MAX   = 1024;
	localparam int SAMPLE_WIDTH = 16;
	localparam int CFG_W        = swa_pkg::CFG_W;
	localparam int CLK_PERIOD   = 10;
	// window of the long fill pass with the most negative sample
	localparam int WIDE_WINDOW  = WINDOW_MAX / 2;
	// random samples after the directed table and the long fill pass
	localparam int RANDOM_ITEMS = 260;
	// the tail of the random part runs with no idling at all
	localparam int QUIET_TAIL   = 100;
	// long receiver hold-off, long enough to back the block up to its input
	localparam int LONG_HOLD    = 300;
	// drain margin after the last result, with slack for stray results
	localparam int DRAIN_CYCLES = 40;

	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = 16'sh8000;

	typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_e;

	// one result transfer
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] average;
		logic                           window_full;
	} avg_result_t;

	typedef struct {
		row_kind_e                      kind;
		logic [swa_pkg::CFG_W-1:0]      win;
		logic signed [SAMPLE_WIDTH-1:0] smp;
		bit                             typed;
		logic signed [SAMPLE_WIDTH-1:0] avg;
		bit                             full;
	} directed_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic signed [SAMPLE_WIDTH-1:0] sample = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] average;
	logic                           window_full;
	logic                           win_len_we = 1'b0;
	logic [swa_pkg::CFG_W-1:0]      win_len = '0;

	// predictor state: shadow of the ring, the slot, the count and the sum
	logic signed [SAMPLE_WIDTH-1:0] ring_copy [0:WINDOW_MAX-1];
	logic [swa_pkg::CFG_W-1:0]      window_cfg = CFG_W'(swa_pkg::WIN_RESET);
	int unsigned                    next_slot = 0;
	int unsigned                    held_count = 0;
	longint                         window_sum = 0;

	// expected averages, oldest first
	avg_result_t pending_averages [$];

	int mismatch_count = 0;
	bit gaps_on = 1'b1;
	// long hold-off request from the sender side, and its completion from the result side
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	// directed table: extremes, truncation toward zero, window sizes 1, 0, 2, 2047, 1025, 3;
	// the expected result is typed in only where it is obvious, the rest comes from the predictor
	directed_row_t directed_rows [0:26] = '{
		// reset window of 16, warm-up
		'{ROW_SAMPLE, 11'd0,    SMP_MAX,        1'b1, SMP_MAX,    1'b0},
		'{ROW_SAMPLE, 11'd0,    SMP_MIN,        1'b1, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    SMP_MIN,        1'b0, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    16'sd0,         1'b0, 16'sd0,     1'b0},
		// window of one: the average is the sample
		'{ROW_WINDOW, 11'd1,    16'sd0,         1'b0, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    SMP_MIN,        1'b1, SMP_MIN,    1'b1},
		'{ROW_SAMPLE, 11'd0,    SMP_MAX,        1'b1, SMP_MAX,    1'b1},
		// zero acts as a window of one
		'{ROW_WINDOW, 11'd0,    16'sd0,         1'b0, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    SMP_MIN,        1'b1, SMP_MIN,    1'b1},
		'{ROW_SAMPLE, 11'd0,    16'sd1,         1'b1, 16'sd1,     1'b1},
		// window of two: fill, wrap, negative truncation
		'{ROW_WINDOW, 11'd2,    16'sd0,         1'b0, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    16'sd3,         1'b1, 16'sd3,     1'b0},
		'{ROW_SAMPLE, 11'd0,    16'sd4,         1'b1, 16'sd3,     1'b1},
		'{ROW_SAMPLE, 11'd0,    -16'sd4,        1'b1, 16'sd0,     1'b1},
		'{ROW_SAMPLE, 11'd0,    -16'sd5,        1'b1, -16'sd4,    1'b1},
		'{ROW_SAMPLE, 11'd0,    SMP_MAX,        1'b0, 16'sd0,     1'b0},
		// all-ones register saturates to the largest window
		'{ROW_WINDOW, 11'd2047, 16'sd0,         1'b0, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    -16'sd1,        1'b1, -16'sd1,    1'b0},
		'{ROW_SAMPLE, 11'd0,    -16'sd2,        1'b1, -16'sd1,    1'b0},
		// just above the largest window
		'{ROW_WINDOW, 11'd1025, 16'sd0,         1'b0, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    SMP_MAX,        1'b1, SMP_MAX,    1'b0},
		// odd window with alternating bit patterns
		'{ROW_WINDOW, 11'd3,    16'sd0,         1'b0, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    16'sh5555,      1'b0, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    16'shaaaa,      1'b0, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    16'sd1,         1'b0, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    -16'sd1,        1'b0, 16'sd0,     1'b0},
		'{ROW_SAMPLE, 11'd0,    SMP_MAX,        1'b0, 16'sd0,     1'b0}
	};

	sliding_window_average #(
		.WINDOW_MAX   (WINDOW_MAX),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.average     (average),
		.window_full (window_full),
		.win_len_we  (win_len_we),
		.win_len     (win_len)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// window length in use: zero counts as one, anything above the maximum saturates
	function automatic int unsigned clamp_window(input logic [swa_pkg::CFG_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > WINDOW_MAX)
			return WINDOW_MAX;
		return w;
	endfunction

	// advance the shadow window by one sample and return the average it yields
	function automatic avg_result_t predict_average(input logic signed [SAMPLE_WIDTH-1:0] s);
		int unsigned span;
		int unsigned slot;
		avg_result_t res;
		span = clamp_window(window_cfg);
		slot = (next_slot >= span) ? 0 : next_slot;
		// oldest sample leaves only once the window is full
		if (held_count >= span) begin
			held_count = span;
			window_sum -= ring_copy[slot];
		end else begin
			held_count++;
		end
		ring_copy[slot] = s;
		window_sum += s;
		slot++;
		next_slot = (slot >= span) ? 0 : slot;
		// longint division truncates toward zero
		res.average = SAMPLE_WIDTH'(window_sum / longint'(held_count));
		res.window_full = (held_count == span);
		return res;
	endfunction

	// mostly full-range values, with extremes and values around zero mixed in
	function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return SMP_MIN;
			1: return SMP_MAX;
			2: return SAMPLE_WIDTH'($urandom_range(0, 64) - 32);
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	// mostly short windows, now and then a medium one or a saturating register value
	function automatic logic [swa_pkg::CFG_W-1:0] pick_window();
		case ($urandom_range(0, 11))
			0: return CFG_W'(0);
			1: return CFG_W'(2047);
			2: return CFG_W'($urandom_range(1024, 1100));
			3, 4: return CFG_W'($urandom_range(33, 100));
			default: return CFG_W'($urandom_range(1, 32));
		endcase
	endfunction

	// one sample transfer; valid stays high afterwards so back-to-back items need no toggle
	task automatic offer_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input bit typed,
			input avg_result_t typed_res);
		avg_result_t res;
		@(negedge clk);
		if (gaps_on && !(hold_req && !hold_done) && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid = 1'b1;
		sample = s;
		do
			@(posedge clk);
		while (in_stall);
		res = predict_average(s);
		pending_averages.push_back(typed ? typed_res : res);
	endtask

	// stop offering and wait until every expected average has come back
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	// register write, only ever called right after settle, so the block is idle
	task automatic write_window(input logic [swa_pkg::CFG_W-1:0] w);
		win_len_we = 1'b1;
		win_len = w;
		@(negedge clk);
		win_len_we = 1'b0;
		// a write restarts the filter
		window_cfg = w;
		next_slot = 0;
		held_count = 0;
		window_sum = 0;
	endtask

	// result side: random stall bursts, one long hold-off on request, none in the quiet tail
	initial begin : result_stall
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
			end else if (!gaps_on) begin
				out_stall = 1'b0;
			end else if (burst > 0) begin
				out_stall = 1'b1;
				burst--;
			end else if ($urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				burst = $urandom_range(0, 16);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// every result transfer is compared with the oldest expectation
	always @(posedge clk) begin : result_check
		avg_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_averages.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result average=%0d window_full=%0b",
						$time, average, window_full);
			end else begin
				want = pending_averages.pop_front();
				if (average !== want.average || window_full !== want.window_full) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch average exp %0d got %0d, window_full exp %0b got %0b",
							$time, want.average, average, want.window_full, window_full);
				end
			end
		end
	end

	// hard stop, several times the slowest correct run
	initial begin : run_limit
		#8ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		avg_result_t typed_res;
		logic [swa_pkg::CFG_W-1:0] win;
		int unsigned span;
		int unsigned n_items;
		int random_count;
		int phase;

		// reset once, released away from the sampling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_WINDOW) begin
				settle();
				write_window(directed_rows[r].win);
			end else begin
				typed_res.average = directed_rows[r].avg;
				typed_res.window_full = directed_rows[r].full;
				offer_sample(directed_rows[r].smp, directed_rows[r].typed, typed_res);
			end
		end

		// wide window filled with the most negative sample: a wide negative sum,
		// then the ring wraps and old entries start leaving
		settle();
		write_window(CFG_W'(WIDE_WINDOW));
		typed_res = '0;
		repeat (WIDE_WINDOW) offer_sample(SMP_MIN, 1'b0, typed_res);
		repeat (8) offer_sample(rand_sample(), 1'b0, typed_res);

		// random phases, each with its own window; windows up to 100 run long enough to fill and wrap
		random_count = 0;
		phase = 0;
		while (random_count < RANDOM_ITEMS) begin
			win = pick_window();
			settle();
			write_window(win);
			span = clamp_window(win);
			n_items = (span > 100) ? $urandom_range(5, 30) : span + $urandom_range(1, span + 8);
			for (int k = 0; k < n_items; k++) begin
				// receiver holds off while the sender keeps offering, backing up the block
				if (phase == 0 && k == 1)
					hold_req = 1'b1;
				// sender pause until everything in flight has come back
				if (phase == 1 && k == n_items / 2)
					settle();
				if (random_count >= RANDOM_ITEMS - QUIET_TAIL)
					gaps_on = 1'b0;
				offer_sample(rand_sample(), 1'b0, typed_res);
				random_count++;
			end
			phase++;
		end

		// drain, then a margin for stray results
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_averages.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
